// File: rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants of the countdown timer pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctp_pkg;

  // Default pool size and result limits
  localparam int unsigned NumTimersDef = 8;
  localparam int unsigned MaxResults   = 8;

  // Field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned LoadW    = 31;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned StepW    = 10;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

  localparam logic [StepW-1:0] StepRst = 10'd1;

  // Opcodes
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_SET   = 3'd3,
    OP_STOP  = 3'd4,
    OP_READ  = 3'd5
  } ctp_op_e;

  // Timer modes
  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_RUNNING = 2'd2
  } ctp_mode_e;

  // One timer entry as stored in memory
  typedef struct packed {
    ctp_mode_e        mode;
    logic [TimeW-1:0] remain;
  } ctp_entry_t;

  // One result transaction
  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] rslot;
    logic [TimeW-1:0] time_left;
    logic             expired;
    logic             last;
  } ctp_result_t;

endpackage

// File: rtl/ctp_mem.sv
// ----------------------------------------------------------------------------
// ctp_mem
// Timer state memory: synchronous (registered) read, one write port.
// Per-entry valid bits make never-written entries read as free with time 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_mem import ctp_pkg::*; #(
  parameter int unsigned NumTimers = NumTimersDef,
  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  ctp_entry_t      wr_data_i,
  output ctp_entry_t      rd_data_o
);

  ctp_entry_t           mem_q [NumTimers];
  ctp_entry_t           rd_q;
  logic [NumTimers-1:0] valid_q;
  logic                 rd_valid_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// File: rtl/ctp_out_reg.sv
// ----------------------------------------------------------------------------
// ctp_out_reg
// Output holding register between the sequencer and the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_out_reg import ctp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ld_i,
  input  ctp_result_t res_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        take_i,
  output ctp_result_t res_o
);

  logic        valid_q, valid_d;
  ctp_result_t res_q;

  // Free when empty or drained this cycle
  assign free_o  = !valid_q || take_i;
  assign valid_d = ld_i ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/ctp_seq.sv
// ----------------------------------------------------------------------------
// ctp_seq
// Operation sequencer: reads, modifies and writes back timer entries,
// scans the pool for tick and alloc, queues expiries and issues results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_seq import ctp_pkg::*; #(
  parameter int unsigned NumTimers = NumTimersDef,
  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1,
  localparam int unsigned CntW = $clog2(NumTimers + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [StepW-1:0] step_i,
  // input transactions
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [LoadW-1:0] load_i,
  // memory port
  output logic             mem_rd_en_o,
  output logic [IdxW-1:0]  mem_rd_addr_o,
  output logic             mem_wr_en_o,
  output logic [IdxW-1:0]  mem_wr_addr_o,
  output ctp_entry_t       mem_wr_data_o,
  input  ctp_entry_t       mem_rd_data_i,
  // output register
  output logic             out_ld_o,
  output ctp_result_t      out_res_o,
  input  logic             out_free_i
);

  localparam int unsigned ExpW    = $clog2(MaxResults + 1);
  localparam int unsigned ExpIdxW = $clog2(MaxResults);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LOOK = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_RESP = 5'b10000
  } ctp_state_e;

  ctp_state_e       state_q, state_d;
  logic [OpW-1:0]   op_q;
  logic [SlotW-1:0] slot_q;
  logic [LoadW-1:0] load_q;
  logic [CntW-1:0]  iss_cnt_q, iss_cnt_d;
  logic             pend_q;
  logic [IdxW-1:0]  pidx_q;
  logic [SlotW-1:0] exp_q [MaxResults];
  logic [ExpW-1:0]  exp_cnt_q, exp_cnt_d;
  logic [ExpW-1:0]  emit_cnt_q, emit_cnt_d;
  ctp_result_t      res_q, res_d;
  logic             exp_we;

  logic             accept;
  logic             in_rng;
  logic             live;
  logic             scan_end;
  logic [TimeW-1:0] dec;
  logic             emit_last;
  ctp_entry_t       ent;
  ctp_result_t      emit_res;

  assign accept   = in_valid_i && in_ready_o;
  assign ent      = mem_rd_data_i;
  assign in_rng   = (7'(slot_q) < 7'(NumTimers));
  assign live     = in_rng && (ent.mode != MODE_FREE);
  assign scan_end = pend_q && (pidx_q == IdxW'(NumTimers - 1));
  assign dec      = ent.remain - TimeW'(step_i);

  // Expiry result taken from the queue
  assign emit_last = ((emit_cnt_q + 1'b1) == exp_cnt_q);
  always_comb begin
    emit_res           = '0;
    emit_res.ok        = 1'b1;
    emit_res.rslot     = exp_q[emit_cnt_q[ExpIdxW-1:0]];
    emit_res.expired   = 1'b1;
    emit_res.last      = emit_last;
  end

  // Main sequencing
  always_comb begin
    state_d       = state_q;
    iss_cnt_d     = iss_cnt_q;
    exp_cnt_d     = exp_cnt_q;
    emit_cnt_d    = emit_cnt_q;
    res_d         = res_q;
    exp_we        = 1'b0;
    in_ready_o    = (state_q == ST_IDLE);
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = iss_cnt_q[IdxW-1:0];
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = pidx_q;
    mem_wr_data_o = ent;
    out_ld_o      = 1'b0;
    out_res_o     = res_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_rd_en_o = 1'b1;
          exp_cnt_d   = '0;
          emit_cnt_d  = '0;
          if (op_i == OP_TICK || op_i == OP_ALLOC) begin
            mem_rd_addr_o = '0;
            iss_cnt_d     = CntW'(1);
            state_d       = ST_SCAN;
          end else begin
            mem_rd_addr_o = IdxW'(slot_i);
            state_d       = ST_LOOK;
          end
        end
      end

      ST_SCAN: begin
        if (op_q == OP_ALLOC) begin
          if (pend_q && ent.mode == MODE_FREE) begin
            // claim lowest free slot
            mem_wr_en_o          = 1'b1;
            mem_wr_data_o.mode   = MODE_STOPPED;
            mem_wr_data_o.remain = '0;
            res_d                = '0;
            res_d.ok             = 1'b1;
            res_d.rslot          = SlotW'(pidx_q);
            res_d.last           = 1'b1;
            state_d              = ST_RESP;
          end else begin
            if (iss_cnt_q < CntW'(NumTimers)) begin
              mem_rd_en_o = 1'b1;
              iss_cnt_d   = iss_cnt_q + 1'b1;
            end
            if (scan_end) begin
              res_d      = '0;
              res_d.last = 1'b1;
              state_d    = ST_RESP;
            end
          end
        end else begin
          if (iss_cnt_q < CntW'(NumTimers)) begin
            mem_rd_en_o = 1'b1;
            iss_cnt_d   = iss_cnt_q + 1'b1;
          end
          // count down a running timer, stop it on underflow
          if (pend_q && ent.mode == MODE_RUNNING) begin
            mem_wr_en_o          = 1'b1;
            mem_wr_data_o.remain = dec;
            mem_wr_data_o.mode   = dec[TimeW-1] ? MODE_STOPPED : MODE_RUNNING;
            if (dec[TimeW-1] && exp_cnt_q < ExpW'(MaxResults)) begin
              exp_we    = 1'b1;
              exp_cnt_d = exp_cnt_q + 1'b1;
            end
          end
          if (scan_end) begin
            if (exp_cnt_d != '0) begin
              state_d = ST_EMIT;
            end else begin
              res_d      = '0;
              res_d.ok   = 1'b1;
              res_d.last = 1'b1;
              state_d    = ST_RESP;
            end
          end
        end
      end

      ST_LOOK: begin
        mem_wr_addr_o = IdxW'(slot_q);
        res_d         = '0;
        res_d.last    = 1'b1;
        case (op_q)
          OP_FREE: begin
            if (in_rng) begin
              mem_wr_en_o        = 1'b1;
              mem_wr_data_o.mode = MODE_FREE;
              res_d.ok           = 1'b1;
            end
          end
          OP_SET: begin
            if (live) begin
              mem_wr_en_o          = 1'b1;
              mem_wr_data_o.mode   = MODE_RUNNING;
              mem_wr_data_o.remain = TimeW'(load_q);
              res_d.ok             = 1'b1;
            end
          end
          OP_STOP: begin
            if (live) begin
              mem_wr_en_o        = 1'b1;
              mem_wr_data_o.mode = MODE_STOPPED;
              res_d.ok           = 1'b1;
            end
          end
          OP_READ: begin
            if (live) begin
              res_d.ok        = 1'b1;
              res_d.time_left = ent.remain;
            end
          end
          default: begin
            res_d.ok = 1'b0;
          end
        endcase
        state_d = ST_RESP;
      end

      ST_EMIT: begin
        out_res_o = emit_res;
        if (out_free_i) begin
          out_ld_o   = 1'b1;
          emit_cnt_d = emit_cnt_q + 1'b1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_RESP: begin
        if (out_free_i) begin
          out_ld_o = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_cnt_q  <= '0;
      pend_q     <= 1'b0;
      exp_cnt_q  <= '0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      iss_cnt_q  <= iss_cnt_d;
      pend_q     <= mem_rd_en_o;
      exp_cnt_q  <= exp_cnt_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      slot_q <= slot_i;
      load_q <= load_i;
    end
    if (mem_rd_en_o) begin
      pidx_q <= mem_rd_addr_o;
    end
    if (exp_we) begin
      exp_q[exp_cnt_q[ExpIdxW-1:0]] <= SlotW'(pidx_q);
    end
    res_q <= res_d;
  end

endmodule

// File: rtl/countdown_timer_pool_core.sv
// ----------------------------------------------------------------------------
// countdown_timer_pool_core
// Tick walks the state memory one entry a cycle and then returns one result
// per queued expiry, or a single result when none expired. Alloc stops at the
// first free slot. Other opcodes read, modify/write, then return a result.
// One transaction in flight at a time; a stalled result holds the input off.
// Reset clears all timers to free and ms_per_tick to 1; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_pool_core import ctp_pkg::*; #(
  parameter int unsigned NumTimers = NumTimersDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: opcode[2:0], slot[5:3], load_ms[36:6], zero[39:37]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata: ok[0], result_slot[3:1], time_left[35:4], zero[39:36]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // tuser: expired[0]
  output logic [0:0]           m_axis_tuser_o,
  output logic                 m_axis_tlast_o,
  // ms_per_tick register
  input  logic                 cfg_we_i,
  input  logic [StepW-1:0]     cfg_wdata_i
);

  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;

  logic [StepW-1:0] step_q;
  logic             rd_en, wr_en;
  logic [IdxW-1:0]  rd_addr, wr_addr;
  ctp_entry_t       wr_data, rd_data;
  logic             out_ld, out_free;
  ctp_result_t      seq_res, out_res;

  // ms_per_tick register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepRst;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  ctp_mem #(.NumTimers(NumTimers)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  ctp_seq #(.NumTimers(NumTimers)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .op_i          (s_axis_tdata_i[2:0]),
    .slot_i        (s_axis_tdata_i[5:3]),
    .load_i        (s_axis_tdata_i[36:6]),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data),
    .mem_rd_data_i (rd_data),
    .out_ld_o      (out_ld),
    .out_res_o     (seq_res),
    .out_free_i    (out_free)
  );

  ctp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (out_ld),
    .res_i   (seq_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (out_res)
  );

  // Result packing
  assign m_axis_tdata_o = {4'b0, out_res.time_left, out_res.rslot, out_res.ok};
  assign m_axis_tuser_o = out_res.expired;
  assign m_axis_tlast_o = out_res.last;

endmodule

// File: rtl/ctp_checker.sv
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks on the result stream of the timer pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_checker import ctp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic [0:0]           m_axis_tuser_o,
  input logic                 m_axis_tlast_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Only tick expiries can be followed by more results
  a_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o[0])
    else $error("non-final result that is not an expiry");

  // A failed operation carries no slot, time or expiry
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |->
      m_axis_tdata_o[OutTdataW-1:1] == '0 && !m_axis_tuser_o[0])
    else $error("failed result with nonzero fields");

  // Expiries succeed and report no time
  a_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      m_axis_tdata_o[0] && m_axis_tdata_o[OutTdataW-1:4] == '0)
    else $error("expiry with bad ok or time");

endmodule

bind countdown_timer_pool_core ctp_checker u_ctp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
